### hdl/ffba_pkg.sv
// Shared constants for the first-fit block allocator.
package ffba_pkg;

  localparam int MaxBlocksDefault = 64;
  localparam int AddrBitsDefault  = 32;
  localparam logic [31:0] ResetCapacity = 32'd65536;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TABLE_FULL = 2'd1,
    STATUS_CAP_OVF   = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

endpackage

### hdl/ffba_ram.sv
// Generic single write, single read RAM with registered read data.
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/first_fit_block_allocator_core.sv
// First-fit block allocator top level: block table walk, split, growth and merge sequencer.
//
// The block keeps an ordered table of blocks (offset, size, free) in one RAM and
// handles one request at a time. An allocate walks the table entry by entry until
// the first free block that fits, then writes it back and, when a remainder is
// split off, moves every later entry up one place. When nothing fits, the S_GROW_A
// and S_GROW_B states work out the grown region. A free walks the table the same
// way, reads the next entry, writes the merged block and moves later entries down.
// No request walks and moves more entries than are in use. After reset or a write
// of initial_capacity the block writes the first table entry in its S_INIT state
// before it takes an item. The finished result sits in an output register, so the
// next item may be taken while it waits.
module first_fit_block_allocator_core #(
  parameter int MAX_BLOCKS = ffba_pkg::MaxBlocksDefault,
  parameter int ADDR_BITS  = ffba_pkg::AddrBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] initial_capacity,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [31:0] length,
  input  logic [31:0] position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] granted_offset,
  output logic        grew,
  output logic [31:0] capacity
);

  localparam int A  = ADDR_BITS;
  localparam int EW = 2 * A + 1;
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int SW = ((A > 32) ? A : 32) + 1;
  localparam logic [A-1:0]  CapLimit = '1;
  localparam logic [CW-1:0] MaxCount = CW'(MAX_BLOCKS);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_GROW_A, S_GROW_B, S_TAKE_WR,
    S_SHUP_RD, S_SHUP_WR, S_SPLIT_WR, S_NEXT_RD, S_NEXT_CHK, S_MERGE_WR,
    S_SHDN_RD, S_SHDN_WR, S_RESP
  } state_t;

  state_t state;

  logic [CW-1:0] count;
  logic [A-1:0]  region;
  logic [CW-1:0] ptr;
  logic [CW-1:0] tgt;
  logic          req_func;
  logic [31:0]   req_len;
  logic [31:0]   req_pos;
  logic [1:0]    res_status;
  logic [A-1:0]  granted;
  logic          res_grew;
  logic [SW-1:0] blk_size;
  logic [SW-1:0] rem;
  logic          prev_free;
  logic [A-1:0]  prev_size;
  logic [A-1:0]  prev_off;
  logic [A-1:0]  cur_size;
  logic [A-1:0]  cur_off;
  logic          hit_prev;
  logic          next_free;
  logic [A-1:0]  next_size;
  logic [1:0]    shift_k;
  logic          tail_free;
  logic          base_gt;
  logic [SW-1:0] diff;
  logic [SW-1:0] start;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;

  logic          e_free;
  logic [A-1:0]  e_size;
  logic [A-1:0]  e_off;
  logic [SW-1:0] len_w;
  logic [SW-1:0] cfg_w;
  logic [SW-1:0] cfg_sat;
  logic [SW-1:0] base_w;
  logic [SW-1:0] newcap;
  logic [CW:0]   need;
  logic [SW-1:0] merged;
  logic [CW-1:0] count_m1;

  ffba_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr[IW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    e_off    = ram_rdata[A-1:0];
    e_size   = ram_rdata[2*A-1:A];
    e_free   = ram_rdata[2*A];
    len_w    = SW'(req_len);
    cfg_w    = SW'(initial_capacity);
    cfg_sat  = (cfg_w > SW'(CapLimit)) ? SW'(CapLimit) : cfg_w;
    base_w   = (SW'(region) > len_w) ? SW'(region) : len_w;
    newcap   = SW'(region) + diff;
    need     = (CW+1)'(count) - (CW+1)'(tail_free) + (CW+1)'(1) + (CW+1)'(base_gt);
    merged   = (hit_prev ? SW'(prev_size) : SW'(0)) + SW'(cur_size) +
               (next_free ? SW'(next_size) : SW'(0));
    count_m1 = count - CW'(1);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tgt[IW-1:0];
    ram_wdata = ram_rdata;
    case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {1'b1, region, {A{1'b0}}};
      end
      S_TAKE_WR: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b0, len_w[A-1:0], granted};
      end
      S_SHUP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(ptr + CW'(1));
      end
      S_SPLIT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(tgt + CW'(1));
        ram_wdata = {1'b1, rem[A-1:0], A'(SW'(granted) + len_w)};
      end
      S_MERGE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = hit_prev ? IW'(tgt - CW'(1)) : tgt[IW-1:0];
        ram_wdata = {1'b1, merged[A-1:0], hit_prev ? prev_off : cur_off};
      end
      S_SHDN_WR: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(ptr - CW'(shift_k));
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      region    <= A'(((SW'(ffba_pkg::ResetCapacity) > SW'(CapLimit)) ?
                       SW'(CapLimit) : SW'(ffba_pkg::ResetCapacity)));
      count     <= CW'(1);
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_RESP || cfg_wr_en)) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        region <= cfg_sat[A-1:0];
        state  <= S_INIT;
      end else begin
        case (state)
          S_INIT: begin
            count <= CW'(1);
            state <= S_IDLE;
          end
          S_IDLE: begin
            if (in_valid) begin
              req_func  <= func;
              req_len   <= length;
              req_pos   <= position;
              granted   <= '0;
              res_grew  <= 1'b0;
              next_free <= 1'b0;
              ptr       <= '0;
              state     <= S_SCAN_RD;
            end
          end
          S_SCAN_RD: begin
            state <= S_SCAN_CHK;
          end
          S_SCAN_CHK: begin
            if (req_func == ffba_pkg::FUNC_ALLOC && e_free && SW'(e_size) >= len_w) begin
              if (SW'(e_size) > len_w && count >= MaxCount) begin
                res_status <= ffba_pkg::STATUS_TABLE_FULL;
                state      <= S_RESP;
              end else begin
                granted  <= e_off;
                tgt      <= ptr;
                blk_size <= SW'(e_size);
                state    <= S_TAKE_WR;
              end
            end else if (req_func == ffba_pkg::FUNC_FREE && !e_free &&
                         SW'(e_off) == SW'(req_pos) && SW'(e_size) == len_w) begin
              tgt      <= ptr;
              cur_size <= e_size;
              cur_off  <= e_off;
              hit_prev <= (ptr != '0) && prev_free;
              if (ptr + CW'(1) < count) begin
                ptr   <= ptr + CW'(1);
                state <= S_NEXT_RD;
              end else begin
                state <= S_MERGE_WR;
              end
            end else begin
              prev_free <= e_free;
              prev_size <= e_size;
              prev_off  <= e_off;
              if (ptr + CW'(1) < count) begin
                ptr   <= ptr + CW'(1);
                state <= S_SCAN_RD;
              end else if (req_func == ffba_pkg::FUNC_ALLOC) begin
                state <= S_GROW_A;
              end else begin
                res_status <= ffba_pkg::STATUS_NOT_FOUND;
                state      <= S_RESP;
              end
            end
          end
          S_GROW_A: begin
            tail_free <= prev_free;
            base_gt   <= base_w > len_w;
            blk_size  <= base_w;
            diff      <= base_w - (prev_free ? SW'(prev_size) : SW'(0));
            start     <= SW'(region) - (prev_free ? SW'(prev_size) : SW'(0));
            state     <= S_GROW_B;
          end
          S_GROW_B: begin
            if (newcap > SW'(CapLimit)) begin
              res_status <= ffba_pkg::STATUS_CAP_OVF;
              state      <= S_RESP;
            end else if (need > (CW+1)'(MAX_BLOCKS)) begin
              res_status <= ffba_pkg::STATUS_TABLE_FULL;
              state      <= S_RESP;
            end else begin
              tgt      <= count - CW'(tail_free);
              count    <= count - CW'(tail_free) + CW'(1);
              region   <= newcap[A-1:0];
              res_grew <= 1'b1;
              granted  <= start[A-1:0];
              state    <= S_TAKE_WR;
            end
          end
          S_TAKE_WR: begin
            rem <= blk_size - len_w;
            if (blk_size != len_w) begin
              if (count_m1 > tgt) begin
                ptr   <= count_m1;
                state <= S_SHUP_RD;
              end else begin
                state <= S_SPLIT_WR;
              end
            end else begin
              res_status <= ffba_pkg::STATUS_OK;
              state      <= S_RESP;
            end
          end
          S_SHUP_RD: begin
            state <= S_SHUP_WR;
          end
          S_SHUP_WR: begin
            if (ptr - CW'(1) > tgt) begin
              ptr   <= ptr - CW'(1);
              state <= S_SHUP_RD;
            end else begin
              state <= S_SPLIT_WR;
            end
          end
          S_SPLIT_WR: begin
            count      <= count + CW'(1);
            res_status <= ffba_pkg::STATUS_OK;
            state      <= S_RESP;
          end
          S_NEXT_RD: begin
            state <= S_NEXT_CHK;
          end
          S_NEXT_CHK: begin
            next_free <= e_free;
            next_size <= e_size;
            state     <= S_MERGE_WR;
          end
          S_MERGE_WR: begin
            shift_k    <= 2'(hit_prev) + 2'(next_free);
            res_status <= ffba_pkg::STATUS_OK;
            if (hit_prev || next_free) begin
              ptr <= tgt + CW'(1) + CW'(next_free);
              if (tgt + CW'(1) + CW'(next_free) < count) begin
                state <= S_SHDN_RD;
              end else begin
                count <= count - CW'(hit_prev) - CW'(next_free);
                state <= S_RESP;
              end
            end else begin
              state <= S_RESP;
            end
          end
          S_SHDN_RD: begin
            state <= S_SHDN_WR;
          end
          S_SHDN_WR: begin
            if (ptr + CW'(1) < count) begin
              ptr   <= ptr + CW'(1);
              state <= S_SHDN_RD;
            end else begin
              count <= count - CW'(shift_k);
              state <= S_RESP;
            end
          end
          S_RESP: begin
            if (!out_valid || !out_stall) begin
              out_valid      <= 1'b1;
              status         <= res_status;
              granted_offset <= (res_status == ffba_pkg::STATUS_OK) ?
                                32'(SW'(granted)) : 32'd0;
              grew           <= (res_status == ffba_pkg::STATUS_OK) && res_grew;
              capacity       <= 32'(SW'(region));
              state          <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count >= CW'(1) && count <= MaxCount)
    else $error("block count out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !cfg_wr_en |=> in_stall)
    else $error("block took an item without going busy");

  a_result_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_RESP))
    else $error("result shown outside the response step");

  a_grew_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && grew |-> status == ffba_pkg::STATUS_OK)
    else $error("growth reported with an error status");
`endif

endmodule

### tb/first_fit_block_allocator_core_tb.sv
// Testbench for the first-fit block allocator: directed and random requests, table model.
module first_fit_block_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK = 64;
  localparam longint unsigned CAP_MAX = 64'hFFFF_FFFF;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  st;
    logic [31:0] off;
    logic        gr;
    logic [31:0] cap;
  } grant_t;

  logic clk = 0, rst = 1;
  logic cfg_wr_en = 0;
  logic [31:0] initial_capacity = 0;
  logic in_valid = 0, func = 0;
  logic [31:0] length = 0, position = 0;
  logic in_stall, out_valid, out_stall = 0;
  logic [1:0] status;
  logic [31:0] granted_offset, capacity;
  logic grew;

  first_fit_block_allocator_core DUT (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .initial_capacity(initial_capacity),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .length(length),
    .position(position), .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .granted_offset(granted_offset), .grew(grew), .capacity(capacity));

  initial forever #5 clk = ~clk;

  // allocator model
  longint unsigned m_off[NBLK];
  longint unsigned m_size[NBLK];
  bit m_free[NBLK];
  int m_count;
  longint unsigned m_region;

  grant_t grants_due[$];
  int errors = 0, idle_cycles = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  // live allocations, for freeing
  longint unsigned held_off[$], held_len[$];

  function automatic void table_reset(longint unsigned cap);
    if (cap > CAP_MAX) cap = CAP_MAX;
    m_off[0] = 0; m_size[0] = cap; m_free[0] = 1;
    m_count = 1; m_region = cap;
  endfunction

  function automatic void drop_at(int i);
    for (int k = i; k < m_count - 1; k++) begin
      m_off[k] = m_off[k+1]; m_size[k] = m_size[k+1]; m_free[k] = m_free[k+1];
    end
    m_count--;
  endfunction

  function automatic void take_at(int i, longint unsigned len);
    longint unsigned rem;
    rem = m_size[i] - len;
    m_free[i] = 0; m_size[i] = len;
    if (rem > 0) begin
      for (int k = m_count; k > i + 1; k--) begin
        m_off[k] = m_off[k-1]; m_size[k] = m_size[k-1]; m_free[k] = m_free[k-1];
      end
      m_off[i+1] = m_off[i] + len; m_size[i+1] = rem; m_free[i+1] = 1;
      m_count++;
    end
  endfunction

  function automatic ffba_pkg::status_t alloc_block(longint unsigned len,
                                                    output longint unsigned off,
                                                    output bit gr);
    bit tail_free;
    longint unsigned tail, base, newcap, start;
    int need;
    off = 0; gr = 0;
    for (int i = 0; i < m_count; i++) begin
      if (m_free[i] && m_size[i] >= len) begin
        if (m_size[i] > len && m_count >= NBLK) return ffba_pkg::STATUS_TABLE_FULL;
        off = m_off[i];
        take_at(i, len);
        return ffba_pkg::STATUS_OK;
      end
    end
    tail_free = m_count > 0 && m_free[m_count-1];
    tail = tail_free ? m_size[m_count-1] : 0;
    base = m_region > len ? m_region : len;
    newcap = m_region + (base - tail);
    start = m_region - tail;
    need = m_count - (tail_free ? 1 : 0) + 1 + (base > len ? 1 : 0);
    if (newcap > CAP_MAX) return ffba_pkg::STATUS_CAP_OVF;
    if (need > NBLK) return ffba_pkg::STATUS_TABLE_FULL;
    if (tail_free) m_count--;
    m_off[m_count] = start; m_size[m_count] = newcap - start; m_free[m_count] = 1;
    m_count++;
    m_region = newcap;
    gr = 1; off = start;
    take_at(m_count - 1, len);
    return ffba_pkg::STATUS_OK;
  endfunction

  function automatic ffba_pkg::status_t free_block(longint unsigned len,
                                                   longint unsigned pos);
    for (int i = 0; i < m_count; i++) begin
      if (!m_free[i] && m_off[i] == pos && m_size[i] == len) begin
        m_free[i] = 1;
        if (i > 0 && m_free[i-1]) begin
          m_size[i-1] += m_size[i];
          drop_at(i);
          i--;
        end
        if (i + 1 < m_count && m_free[i+1]) begin
          m_size[i] += m_size[i+1];
          drop_at(i + 1);
        end
        return ffba_pkg::STATUS_OK;
      end
    end
    return ffba_pkg::STATUS_NOT_FOUND;
  endfunction

  function automatic grant_t predict_grant(ffba_pkg::func_t f, logic [31:0] len,
                                           logic [31:0] pos);
    grant_t g;
    longint unsigned off;
    longint unsigned len_q;
    bit gr;
    len_q = len;
    if (f == ffba_pkg::FUNC_ALLOC) begin
      g.st = alloc_block(len_q, off, gr);
      if (g.st != ffba_pkg::STATUS_OK) begin
        off = 0; gr = 0;
      end else begin
        held_off = {held_off, off};
        held_len = {held_len, len_q};
      end
    end else begin
      g.st = free_block(len_q, pos);
      off = 0; gr = 0;
    end
    g.off = off[31:0]; g.gr = gr; g.cap = m_region[31:0];
    return g;
  endfunction

  task automatic send_request(ffba_pkg::func_t f, logic [31:0] len, logic [31:0] pos);
    grant_t g;
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid <= 1; func <= f; length <= len; position <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    g = predict_grant(f, len, pos);
    grants_due = {grants_due, g};
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic drain();
    int n;
    n = 0;
    while (grants_due.size() != 0) @(negedge clk);
    while (n < 4 * NBLK + 20) begin
      @(negedge clk);
      n++;
    end
  endtask

  task automatic set_capacity(logic [31:0] cap);
    drain();
    cfg_wr_en <= 1; initial_capacity <= cap;
    @(negedge clk);
    cfg_wr_en <= 0;
    table_reset(cap);
    held_off.delete(); held_len.delete();
  endtask

  task automatic free_random_held();
    int k;
    longint unsigned o, l;
    k = $urandom_range(held_off.size() - 1);
    o = held_off[k]; l = held_len[k];
    held_off.delete(k); held_len.delete(k);
    send_request(ffba_pkg::FUNC_FREE, l, o);
  endtask

  // checker
  always @(posedge clk) begin
    grant_t e;
    if (!rst && out_valid && !out_stall) begin
      if (grants_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item: st=%0d off=%h gr=%b cap=%h",
                                   status, granted_offset, grew, capacity);
      end else begin
        e = grants_due.pop_front();
        if (status !== e.st || granted_offset !== e.off || grew !== e.gr ||
            capacity !== e.cap) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp st=%0d off=%h gr=%b cap=%h, got st=%0d off=%h gr=%b cap=%h",
                     e.st, e.off, e.gr, e.cap, status, granted_offset, grew, capacity);
        end
      end
    end
  end

  always @(negedge clk)
    out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("first_fit_block_allocator_core_tb: FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(ffba_pkg::FUNC_ALLOC, 0, 0);
    send_request(ffba_pkg::FUNC_FREE, 0, 0);
    send_request(ffba_pkg::FUNC_ALLOC, 100, 32'hFFFF_FFFF);
    send_request(ffba_pkg::FUNC_ALLOC, 65436, 0);
    send_request(ffba_pkg::FUNC_ALLOC, 10, 0);
    send_request(ffba_pkg::FUNC_FREE, 100, 0);
    send_request(ffba_pkg::FUNC_FREE, 100, 0);
    send_request(ffba_pkg::FUNC_FREE, 7, 3);
    send_request(ffba_pkg::FUNC_ALLOC, 32'hFFFF_FFFF, 0);
    send_request(ffba_pkg::FUNC_ALLOC, 32'hFFFF_0000, 0);
    set_capacity(0);
    send_request(ffba_pkg::FUNC_ALLOC, 0, 0);
    send_request(ffba_pkg::FUNC_ALLOC, 5, 0);
    send_request(ffba_pkg::FUNC_FREE, 5, 0);
    set_capacity(32'hFFFF_FFFF);
    send_request(ffba_pkg::FUNC_ALLOC, 32'h8000_0000, 0);
    send_request(ffba_pkg::FUNC_ALLOC, 32'h7FFF_FFFF, 0);
    send_request(ffba_pkg::FUNC_ALLOC, 1, 0);
    set_capacity(1);
    send_request(ffba_pkg::FUNC_ALLOC, 1, 0);
    send_request(ffba_pkg::FUNC_ALLOC, 1, 0);
    send_request(ffba_pkg::FUNC_FREE, 1, 0);
    send_request(ffba_pkg::FUNC_FREE, 1, 1);
  endtask

  task automatic test_table_full();
    set_capacity(4096);
    for (int i = 0; i < 70; i++) send_request(ffba_pkg::FUNC_ALLOC, 1, 0);
    for (int i = 0; i < 20; i++) free_random_held();
  endtask

  task automatic test_random(int n, logic [31:0] cap);
    logic [31:0] len;
    set_capacity(cap);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: len = $urandom();
        1: len = $urandom_range(3);
        default: len = $urandom_range(cap > 0 && cap < 4096 ? cap : 4096);
      endcase
      if (held_off.size() > 0 && $urandom_range(99) < 45) free_random_held();
      else if ($urandom_range(99) < 5) send_request(ffba_pkg::FUNC_FREE, len, $urandom());
      else send_request(ffba_pkg::FUNC_ALLOC, len, $urandom());
    end
  endtask

  initial begin
    table_reset(ffba_pkg::ResetCapacity);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    send_idle_pct = 15; recv_idle_pct = 79;
    test_directed();
    test_table_full();
    test_random(400, 65536);
    send_idle_pct = 79; recv_idle_pct = 15;
    test_random(400, 1000);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(400, $urandom());
    drain();
    if (errors == 0) $display("first_fit_block_allocator_core_tb: PASS");
    else $display("first_fit_block_allocator_core_tb: FAIL");
    $finish;
  end
endmodule

### sim.f
hdl/ffba_pkg.sv
hdl/ffba_ram.sv
hdl/first_fit_block_allocator_core.sv
tb/first_fit_block_allocator_core_tb.sv
